>>> hdl/bop_pkg.sv
`default_nettype none

package bop_pkg;

  // Sizes and fixed-point formats.
  localparam int MAX_STEPS  = 1024;
  localparam int FRAC_BITS  = 30;
  localparam int PRICE_FRAC = 16;
  localparam int OUT_FRAC   = 30;
  localparam int PRICE_W    = 48;
  localparam int FACTOR_W   = 32;
  localparam int STEP_W     = 11;
  localparam int NODE_DEPTH = MAX_STEPS + 1;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int HALF_W     = PRICE_W / 2;
  localparam int PP_W       = HALF_W + FACTOR_W;
  localparam int PROD_W     = PRICE_W + FACTOR_W;
  localparam int DIV_BITS   = 96;
  localparam int DIV_CNT_W  = $clog2(DIV_BITS);
  localparam int DMAG_W     = PRICE_W + 1;

  localparam logic [30:0] PROB_ONE = 31'(1) << FRAC_BITS;

  // Quotient limits.
  localparam logic [63:0] DELTA_LIM_POS = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] DELTA_LIM_NEG = 64'h0000_0000_8000_0000;
  localparam logic [63:0] DERIV_LIM     = 64'(1) << 61;
  localparam logic [63:0] GAMMA_LIM_POS = (64'(1) << 47) - 64'(1);
  localparam logic [63:0] GAMMA_LIM_NEG = 64'(1) << 47;

  typedef struct packed {
    logic [47:0] spot_price;
    logic [47:0] strike_price;
    logic        is_call;
  } item_t;

  typedef struct packed {
    logic [47:0]        option_value;
    logic signed [31:0] price_delta;
    logic signed [47:0] price_gamma;
    logic               status;
  } result_t;

  typedef enum logic [2:0] {
    CFG_STEP_COUNT = 3'd0,
    CFG_UP         = 3'd1,
    CFG_DOWN       = 3'd2,
    CFG_DISC       = 3'd3,
    CFG_PROB       = 3'd4,
    CFG_LOW_LEAF   = 3'd5,
    CFG_AT_EXPIRY  = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_LEAF, MUL_PU1, MUL_PU2, MUL_NAP, MUL_VP, MUL_VQ, MUL_VD,
    MUL_SU, MUL_SD, MUL_SUU, MUL_SDD
  } mul_op_t;

  typedef enum logic [1:0] {
    DIV_DELTA, DIV_DU, DIV_DD, DIV_GAMMA
  } div_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LEAF0, ST_LWRITE, ST_LPU1, ST_LPU2,
    ST_RLEVEL, ST_RLOW, ST_RVP, ST_RVQ, ST_RVD, ST_RPU1, ST_RPU2,
    ST_FSU, ST_FSD, ST_FSUU, ST_FSDD,
    ST_DDELTA, ST_DDU, ST_DDD, ST_DGAM, ST_DONE
  } state_t;

  typedef struct packed {
    logic               load;
    mul_op_t            mul_op;
    logic               mul_go;
    div_op_t            div_op;
    logic               div_go;
    logic               leaf_wr;
    logic               load_lower;
    logic               cap_lv1;
    logic               cap_lv2;
    logic [1:0]         cap_idx;
    logic [NODE_AW-1:0] wr_addr;
    logic [NODE_AW-1:0] rd_addr;
    logic               emit;
  } cmd_t;

  typedef struct packed {
    logic              mul_done;
    logic              div_done;
    logic              den_zero;
    logic              gamma_ok;
    logic              expiry;
    logic [STEP_W-1:0] steps;
  } sts_t;

  typedef struct packed {
    logic        neg;
    logic [47:0] mag;
  } smag_t;

  // Intrinsic value of a call or a put.
  function automatic logic [47:0] payoff(input logic [47:0] s, input logic [47:0] k,
                                         input logic call);
    logic [47:0] r;
    if (call) begin
      r = (s > k) ? s - k : '0;
    end else begin
      r = (k > s) ? k - s : '0;
    end
    return r;
  endfunction

  // Sign and magnitude of a - b.
  function automatic smag_t sub_mag(input logic [47:0] a, input logic [47:0] b);
    smag_t r;
    if (a >= b) begin
      r.neg = 1'b0;
      r.mag = a - b;
    end else begin
      r.neg = 1'b1;
      r.mag = b - a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hdl/binomial_american_option_pricer_top.sv
`default_nettype none

// Channel   Ports                              Transaction
// input     start, busy, in_item              start high while busy low
// result    out_valid, out_result             out_valid high for one cycle
// config    cfg_we, cfg_index, cfg_data       cfg_we high, no wait
//
// One option walks the N-step tree and then runs the delta and gamma divisions;
// expiry mode skips the tree and gives the payoff directly.
// All products go through the one shared 24x32 multiplier, which forms each
// product from the low and high halves of the price, also during rollback.
// Reset is synchronous and active low; the node store needs no clearing.
// The receiver cannot stall: each result is shown for exactly one cycle.
module binomial_american_option_pricer_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire bop_pkg::item_t   in_item,
  output logic                  out_valid,
  output bop_pkg::result_t      out_result,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data
);

  bop_pkg::cmd_t cmd;
  bop_pkg::sts_t sts;

  // Sequencer.
  bop_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Arithmetic, node store and configuration.
  bop_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_result(out_result)
  );

endmodule

`default_nettype wire

>>> hdl/bop_ram.sv
`default_nettype none

module bop_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1025,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/bop_datapath.sv
`default_nettype none

module bop_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  input  wire bop_pkg::item_t   in_item,
  input  wire bop_pkg::cmd_t    cmd,
  output bop_pkg::sts_t         sts,
  output bop_pkg::result_t      out_result
);

  // Configuration registers.
  logic [bop_pkg::STEP_W-1:0] step_count_r;
  logic [31:0]                up_r;
  logic [31:0]                down_r;
  logic [30:0]                disc_r;
  logic [30:0]                prob_r;
  logic [31:0]                low_leaf_r;
  logic                       at_exp_r;

  // Item and tree registers.
  logic [47:0] s_r, k_r;
  logic        call_r;
  logic [47:0] price_r, nap_r, tmp_r, sum_r, lower_r, root_r;
  logic [47:0] su_r, sd_r, suu_r, sdd_r;
  logic [47:0] lv1_r [2];
  logic [47:0] lv2_r [3];
  logic signed [31:0] delta_r;
  logic signed [63:0] du_r, dd_r;
  logic signed [47:0] gamma_r;
  logic        ovf_r;
  bop_pkg::result_t out_r;

  // Multiplier.
  logic [1:0]               mul_ph_r;
  logic [bop_pkg::PP_W-1:0] pp_r, lo_r;
  logic [47:0]              mul_a;
  logic [31:0]              mul_f;
  logic [bop_pkg::HALF_W-1:0] mul_half;
  logic [bop_pkg::PROD_W-1:0] prod;
  logic                     mul_last, mul_sat;
  logic [47:0]              mul_res;

  // Divider.
  logic                          div_run_r;
  logic [bop_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [bop_pkg::DIV_BITS-1:0]  dvd_r;
  logic [bop_pkg::DMAG_W-1:0]    rem_r, dmag_r;
  logic [63:0]                   q_r, lim_r;
  logic                          dneg_r;
  logic [bop_pkg::DMAG_W:0]      rem2, rem_n;
  logic                          ge, q_sat, div_fin;
  logic [63:0]                   q2, q_fin, div_res;
  logic [bop_pkg::DIV_BITS-1:0]  dvd_load;
  logic [bop_pkg::DMAG_W-1:0]    dmag_load;
  logic                          neg_load;
  logic [63:0]                   lim_load;

  logic [bop_pkg::STEP_W-1:0] steps;
  logic [30:0] p_cl, q1_cl, disc_cl;
  logic [47:0] pay_price, wval, node_rdata;
  logic        node_we;
  bop_pkg::smag_t num1, den1, n2, n1, da, db, dcr;
  logic signed [63:0] g;
  logic [63:0] g_mag;
  logic [46:0] dcm;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r <= bop_pkg::STEP_W'(1);
      up_r         <= 32'h4000_0000;
      down_r       <= 32'h4000_0000;
      disc_r       <= 31'h4000_0000;
      prob_r       <= 31'h2000_0000;
      low_leaf_r   <= 32'h4000_0000;
      at_exp_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (bop_pkg::cfg_idx_t'(cfg_index))
        bop_pkg::CFG_STEP_COUNT: step_count_r <= cfg_data[bop_pkg::STEP_W-1:0];
        bop_pkg::CFG_UP:         up_r         <= cfg_data;
        bop_pkg::CFG_DOWN:       down_r       <= cfg_data;
        bop_pkg::CFG_DISC:       disc_r       <= cfg_data[30:0];
        bop_pkg::CFG_PROB:       prob_r       <= cfg_data[30:0];
        bop_pkg::CFG_LOW_LEAF:   low_leaf_r   <= cfg_data;
        bop_pkg::CFG_AT_EXPIRY:  at_exp_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamped step count, probabilities and discount.
  always_comb begin
    if (step_count_r == '0) begin
      steps = bop_pkg::STEP_W'(1);
    end else if (step_count_r > bop_pkg::STEP_W'(bop_pkg::MAX_STEPS)) begin
      steps = bop_pkg::STEP_W'(bop_pkg::MAX_STEPS);
    end else begin
      steps = step_count_r;
    end
    p_cl    = (prob_r < bop_pkg::PROB_ONE) ? prob_r : bop_pkg::PROB_ONE;
    q1_cl   = bop_pkg::PROB_ONE - p_cl;
    disc_cl = (disc_r < bop_pkg::PROB_ONE) ? disc_r : bop_pkg::PROB_ONE;
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = s_r;
    mul_f = up_r;
    unique case (cmd.mul_op)
      bop_pkg::MUL_LEAF: begin mul_a = s_r;        mul_f = low_leaf_r;     end
      bop_pkg::MUL_PU1:  begin mul_a = price_r;    mul_f = up_r;           end
      bop_pkg::MUL_PU2:  begin mul_a = tmp_r;      mul_f = up_r;           end
      bop_pkg::MUL_NAP:  begin mul_a = nap_r;      mul_f = up_r;           end
      bop_pkg::MUL_VP:   begin mul_a = node_rdata; mul_f = {1'b0, p_cl};   end
      bop_pkg::MUL_VQ:   begin mul_a = lower_r;    mul_f = {1'b0, q1_cl};  end
      bop_pkg::MUL_VD:   begin mul_a = sum_r;      mul_f = {1'b0, disc_cl}; end
      bop_pkg::MUL_SU:   begin mul_a = s_r;        mul_f = up_r;           end
      bop_pkg::MUL_SD:   begin mul_a = s_r;        mul_f = down_r;         end
      bop_pkg::MUL_SUU:  begin mul_a = su_r;       mul_f = up_r;           end
      bop_pkg::MUL_SDD:  begin mul_a = sd_r;       mul_f = down_r;         end
      default: ;
    endcase
  end

  // Product in two halves: low half first, high half second, then the sum of the two.
  assign mul_half = (mul_ph_r == 2'd0) ? mul_a[bop_pkg::HALF_W-1:0]
                                       : mul_a[bop_pkg::PRICE_W-1:bop_pkg::HALF_W];
  assign mul_last = cmd.mul_go && (mul_ph_r == 2'd2);
  assign prod     = {pp_r, {bop_pkg::HALF_W{1'b0}}} +
                    {{bop_pkg::HALF_W{1'b0}}, lo_r};
  assign mul_sat  = |prod[bop_pkg::PROD_W-1:bop_pkg::FRAC_BITS+bop_pkg::PRICE_W];
  assign mul_res  = mul_sat ? '1 : prod[bop_pkg::FRAC_BITS +: bop_pkg::PRICE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_ph_r <= 2'd0;
    end else if (mul_last) begin
      mul_ph_r <= 2'd0;
    end else if (cmd.mul_go) begin
      mul_ph_r <= mul_ph_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go && (mul_ph_r != 2'd2)) begin
      pp_r <= bop_pkg::PP_W'(mul_half * mul_f);
    end
    if (cmd.mul_go && (mul_ph_r == 2'd1)) begin
      lo_r <= pp_r;
    end
  end

  // Node value: leaf payoff, or the larger of continuation and exercise.
  assign pay_price = bop_pkg::payoff(price_r, k_r, call_r);
  assign wval      = cmd.leaf_wr ? pay_price : ((mul_res > pay_price) ? mul_res : pay_price);
  assign node_we   = cmd.leaf_wr || (mul_last && (cmd.mul_op == bop_pkg::MUL_VD));

  bop_ram #(
    .WIDTH(bop_pkg::PRICE_W),
    .DEPTH(bop_pkg::NODE_DEPTH)
  ) u_node_ram (
    .clk  (clk),
    .we   (node_we),
    .waddr(cmd.wr_addr),
    .wdata(wval),
    .raddr(cmd.rd_addr),
    .rdata(node_rdata)
  );

  // Tree registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r    <= in_item.spot_price;
      k_r    <= in_item.strike_price;
      call_r <= in_item.is_call;
    end
    if (cmd.load_lower) begin
      lower_r <= node_rdata;
    end
    if (node_we) begin
      root_r <= wval;
      if (cmd.cap_lv1) begin
        lv1_r[cmd.cap_idx[0]] <= wval;
      end
      if (cmd.cap_lv2) begin
        lv2_r[cmd.cap_idx] <= wval;
      end
    end
    if (mul_last) begin
      unique case (cmd.mul_op)
        bop_pkg::MUL_LEAF: begin price_r <= mul_res; nap_r <= mul_res; end
        bop_pkg::MUL_PU1:  tmp_r <= mul_res;
        bop_pkg::MUL_PU2:  price_r <= mul_res;
        bop_pkg::MUL_NAP:  begin price_r <= mul_res; nap_r <= mul_res; end
        bop_pkg::MUL_VP:   tmp_r <= mul_res;
        bop_pkg::MUL_VQ:   sum_r <= tmp_r + mul_res;
        bop_pkg::MUL_VD:   lower_r <= node_rdata;
        bop_pkg::MUL_SU:   su_r <= mul_res;
        bop_pkg::MUL_SD:   sd_r <= mul_res;
        bop_pkg::MUL_SUU:  suu_r <= mul_res;
        bop_pkg::MUL_SDD:  sdd_r <= mul_res;
        default: ;
      endcase
    end
  end

  // Divider operands for delta, the two level-two deltas and gamma.
  always_comb begin
    num1  = bop_pkg::sub_mag(lv1_r[1], lv1_r[0]);
    den1  = bop_pkg::sub_mag(su_r, sd_r);
    n2    = bop_pkg::sub_mag(lv2_r[2], lv2_r[1]);
    n1    = bop_pkg::sub_mag(lv2_r[1], lv2_r[0]);
    da    = bop_pkg::sub_mag(suu_r, s_r);
    db    = bop_pkg::sub_mag(s_r, sdd_r);
    dcr   = bop_pkg::sub_mag(suu_r, sdd_r);
    dcm   = dcr.mag[47:1];
    g     = du_r - dd_r;
    g_mag = g[63] ? (64'(0) - g) : g;
    dvd_load  = bop_pkg::DIV_BITS'(num1.mag) << bop_pkg::OUT_FRAC;
    dmag_load = {1'b0, den1.mag};
    neg_load  = num1.neg ^ den1.neg;
    lim_load  = neg_load ? bop_pkg::DELTA_LIM_NEG : bop_pkg::DELTA_LIM_POS;
    unique case (cmd.div_op)
      bop_pkg::DIV_DELTA: ;
      bop_pkg::DIV_DU: begin
        dvd_load  = bop_pkg::DIV_BITS'(n2.mag) << bop_pkg::OUT_FRAC;
        dmag_load = {1'b0, da.mag};
        neg_load  = n2.neg ^ da.neg;
        lim_load  = bop_pkg::DERIV_LIM;
      end
      bop_pkg::DIV_DD: begin
        dvd_load  = bop_pkg::DIV_BITS'(n1.mag) << bop_pkg::OUT_FRAC;
        dmag_load = {1'b0, db.mag};
        neg_load  = n1.neg ^ db.neg;
        lim_load  = bop_pkg::DERIV_LIM;
      end
      bop_pkg::DIV_GAMMA: begin
        dvd_load  = bop_pkg::DIV_BITS'(g_mag[62:0]) << bop_pkg::PRICE_FRAC;
        dmag_load = bop_pkg::DMAG_W'(dcm);
        neg_load  = g[63] ^ dcr.neg;
        lim_load  = neg_load ? bop_pkg::GAMMA_LIM_NEG : bop_pkg::GAMMA_LIM_POS;
      end
      default: ;
    endcase
  end

  // One quotient bit a cycle; a quotient past its limit stops at the limit.
  always_comb begin
    rem2    = {rem_r, dvd_r[bop_pkg::DIV_BITS-1]};
    ge      = rem2 >= {1'b0, dmag_r};
    rem_n   = ge ? rem2 - {1'b0, dmag_r} : rem2;
    q2      = {q_r[62:0], ge};
    q_sat   = q2 > lim_r;
    div_fin = div_run_r && (q_sat || (div_cnt_r == bop_pkg::DIV_CNT_W'(bop_pkg::DIV_BITS - 1)));
    q_fin   = q_sat ? lim_r : q2;
    div_res = dneg_r ? (64'(0) - q_fin) : q_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
    end else if (div_fin) begin
      div_run_r <= 1'b0;
    end else if (cmd.div_go) begin
      div_run_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go && !div_run_r) begin
      dvd_r     <= dvd_load;
      rem_r     <= '0;
      q_r       <= '0;
      div_cnt_r <= '0;
      dmag_r    <= dmag_load;
      dneg_r    <= neg_load;
      lim_r     <= lim_load;
    end else if (div_run_r) begin
      dvd_r     <= dvd_r << 1;
      rem_r     <= rem_n[bop_pkg::DMAG_W-1:0];
      q_r       <= q2;
      div_cnt_r <= div_cnt_r + bop_pkg::DIV_CNT_W'(1);
    end
  end

  // Sensitivities; delta and gamma are cleared per transaction so skipped ones read as zero.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      delta_r <= '0;
      gamma_r <= '0;
    end else if (div_fin) begin
      unique case (cmd.div_op)
        bop_pkg::DIV_DELTA: delta_r <= div_res[31:0];
        bop_pkg::DIV_DU:    du_r    <= div_res;
        bop_pkg::DIV_DD:    dd_r    <= div_res;
        bop_pkg::DIV_GAMMA: gamma_r <= div_res[47:0];
        default: ;
      endcase
    end
  end

  // Saturation flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r <= 1'b0;
    end else if (cmd.load) begin
      ovf_r <= 1'b0;
    end else if ((mul_last && mul_sat) || (div_fin && q_sat)) begin
      ovf_r <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (at_exp_r) begin
        out_r.option_value <= bop_pkg::payoff(s_r, k_r, call_r);
        out_r.price_delta  <= '0;
        out_r.price_gamma  <= '0;
        out_r.status       <= 1'b0;
      end else begin
        out_r.option_value <= root_r;
        out_r.price_delta  <= delta_r;
        out_r.price_gamma  <= gamma_r;
        out_r.status       <= ovf_r;
      end
    end
  end

  assign out_result   = out_r;
  assign sts.mul_done = mul_last;
  assign sts.div_done = div_fin;
  assign sts.den_zero = (su_r == sd_r);
  assign sts.gamma_ok = (suu_r != s_r) && (s_r != sdd_r) && (dcm != '0);
  assign sts.expiry   = at_exp_r;
  assign sts.steps    = steps;

endmodule

`default_nettype wire

>>> hdl/bop_ctrl.sv
`default_nettype none

module bop_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic               out_valid,
  output bop_pkg::cmd_t      cmd,
  input  wire bop_pkg::sts_t sts
);

  bop_pkg::state_t            state_r, state_nxt;
  logic [bop_pkg::STEP_W-1:0] j_r, j_nxt, level_r, level_nxt, n_r, n_nxt;
  logic                       out_valid_r;
  logic                       j_at_n, j_at_level, rd_next;

  assign j_at_n     = (j_r == n_r);
  assign j_at_level = (j_r == level_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bop_pkg::ST_IDLE:   if (start) begin
        state_nxt = sts.expiry ? bop_pkg::ST_DONE : bop_pkg::ST_LEAF0;
      end
      bop_pkg::ST_LEAF0:  if (sts.mul_done) state_nxt = bop_pkg::ST_LWRITE;
      bop_pkg::ST_LWRITE: state_nxt = j_at_n ? bop_pkg::ST_RLEVEL : bop_pkg::ST_LPU1;
      bop_pkg::ST_LPU1:   if (sts.mul_done) state_nxt = bop_pkg::ST_LPU2;
      bop_pkg::ST_LPU2:   if (sts.mul_done) state_nxt = bop_pkg::ST_LWRITE;
      bop_pkg::ST_RLEVEL: if (sts.mul_done) state_nxt = bop_pkg::ST_RLOW;
      bop_pkg::ST_RLOW:   state_nxt = bop_pkg::ST_RVP;
      bop_pkg::ST_RVP:    if (sts.mul_done) state_nxt = bop_pkg::ST_RVQ;
      bop_pkg::ST_RVQ:    if (sts.mul_done) state_nxt = bop_pkg::ST_RVD;
      bop_pkg::ST_RVD:    if (sts.mul_done) begin
        if (!j_at_level) begin
          state_nxt = bop_pkg::ST_RPU1;
        end else begin
          state_nxt = (level_r == '0) ? bop_pkg::ST_FSU : bop_pkg::ST_RLEVEL;
        end
      end
      bop_pkg::ST_RPU1:   if (sts.mul_done) state_nxt = bop_pkg::ST_RPU2;
      bop_pkg::ST_RPU2:   if (sts.mul_done) state_nxt = bop_pkg::ST_RVP;
      bop_pkg::ST_FSU:    if (sts.mul_done) state_nxt = bop_pkg::ST_FSD;
      bop_pkg::ST_FSD:    if (sts.mul_done) begin
        state_nxt = (n_r >= bop_pkg::STEP_W'(2)) ? bop_pkg::ST_FSUU : bop_pkg::ST_DDELTA;
      end
      bop_pkg::ST_FSUU:   if (sts.mul_done) state_nxt = bop_pkg::ST_FSDD;
      bop_pkg::ST_FSDD:   if (sts.mul_done) state_nxt = bop_pkg::ST_DDELTA;
      bop_pkg::ST_DDELTA: if (sts.den_zero || sts.div_done) begin
        state_nxt = ((n_r >= bop_pkg::STEP_W'(2)) && sts.gamma_ok) ?
                    bop_pkg::ST_DDU : bop_pkg::ST_DONE;
      end
      bop_pkg::ST_DDU:    if (sts.div_done) state_nxt = bop_pkg::ST_DDD;
      bop_pkg::ST_DDD:    if (sts.div_done) state_nxt = bop_pkg::ST_DGAM;
      bop_pkg::ST_DGAM:   if (sts.div_done) state_nxt = bop_pkg::ST_DONE;
      bop_pkg::ST_DONE:   state_nxt = bop_pkg::ST_IDLE;
      default:            state_nxt = bop_pkg::ST_IDLE;
    endcase
  end

  // Loop counters: node index, level and the clamped step count.
  always_comb begin
    j_nxt     = j_r;
    level_nxt = level_r;
    n_nxt     = n_r;
    unique case (state_r)
      bop_pkg::ST_IDLE: if (start) begin
        n_nxt = sts.steps;
        j_nxt = '0;
      end
      bop_pkg::ST_LWRITE: if (j_at_n) begin
        level_nxt = n_r - bop_pkg::STEP_W'(1);
        j_nxt     = '0;
      end
      bop_pkg::ST_LPU2: if (sts.mul_done) j_nxt = j_r + bop_pkg::STEP_W'(1);
      bop_pkg::ST_RVD: if (sts.mul_done && j_at_level && (level_r != '0)) begin
        level_nxt = level_r - bop_pkg::STEP_W'(1);
        j_nxt     = '0;
      end
      bop_pkg::ST_RPU1: if (sts.mul_done) j_nxt = j_r + bop_pkg::STEP_W'(1);
      default: ;
    endcase
  end

  // Commands to the datapath.
  assign rd_next = (state_r == bop_pkg::ST_RLOW) || (state_r == bop_pkg::ST_RVP) ||
                   (state_r == bop_pkg::ST_RVQ)  || (state_r == bop_pkg::ST_RVD) ||
                   (state_r == bop_pkg::ST_RPU1) || (state_r == bop_pkg::ST_RPU2);

  always_comb begin
    cmd         = '0;
    cmd.mul_op  = bop_pkg::MUL_LEAF;
    cmd.div_op  = bop_pkg::DIV_DELTA;
    cmd.wr_addr = bop_pkg::NODE_AW'(j_r);
    cmd.rd_addr = rd_next ? bop_pkg::NODE_AW'(j_r + bop_pkg::STEP_W'(1)) : '0;
    cmd.cap_idx = j_r[1:0];
    unique case (state_r)
      bop_pkg::ST_IDLE:   cmd.load = start;
      bop_pkg::ST_LEAF0:  begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_LEAF; end
      bop_pkg::ST_LWRITE: begin
        cmd.leaf_wr = 1'b1;
        cmd.cap_lv1 = (n_r == bop_pkg::STEP_W'(1));
        cmd.cap_lv2 = (n_r == bop_pkg::STEP_W'(2));
      end
      bop_pkg::ST_LPU1,
      bop_pkg::ST_RPU1:   begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_PU1; end
      bop_pkg::ST_LPU2,
      bop_pkg::ST_RPU2:   begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_PU2; end
      bop_pkg::ST_RLEVEL: begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_NAP; end
      bop_pkg::ST_RLOW:   cmd.load_lower = 1'b1;
      bop_pkg::ST_RVP:    begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_VP; end
      bop_pkg::ST_RVQ:    begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_VQ; end
      bop_pkg::ST_RVD:    begin
        cmd.mul_go  = 1'b1;
        cmd.mul_op  = bop_pkg::MUL_VD;
        cmd.cap_lv1 = (level_r == bop_pkg::STEP_W'(1));
        cmd.cap_lv2 = (level_r == bop_pkg::STEP_W'(2));
      end
      bop_pkg::ST_FSU:    begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_SU; end
      bop_pkg::ST_FSD:    begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_SD; end
      bop_pkg::ST_FSUU:   begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_SUU; end
      bop_pkg::ST_FSDD:   begin cmd.mul_go = 1'b1; cmd.mul_op = bop_pkg::MUL_SDD; end
      bop_pkg::ST_DDELTA: begin cmd.div_go = !sts.den_zero; cmd.div_op = bop_pkg::DIV_DELTA; end
      bop_pkg::ST_DDU:    begin cmd.div_go = 1'b1; cmd.div_op = bop_pkg::DIV_DU; end
      bop_pkg::ST_DDD:    begin cmd.div_go = 1'b1; cmd.div_op = bop_pkg::DIV_DD; end
      bop_pkg::ST_DGAM:   begin cmd.div_go = 1'b1; cmd.div_op = bop_pkg::DIV_GAMMA; end
      bop_pkg::ST_DONE:   cmd.emit = 1'b1;
      default: ;
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bop_pkg::ST_IDLE;
      j_r         <= '0;
      level_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      level_r     <= level_nxt;
      n_r         <= n_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  assign busy      = (state_r != bop_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // A result strobe lasts one cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // An accepted transaction makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transaction accepted but block not busy");

  // The node index never passes the step count.
  a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    j_r <= n_r) else $error("node index beyond step count");

  // During rollback the node index is at most one past its level, and the level is below the step count.
  a_rollback_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_next |-> (j_r <= level_r + bop_pkg::STEP_W'(1)) && (level_r < n_r))
    else $error("rollback index out of range");

endmodule

`default_nettype wire
